// ----- rtl/core/eotq_pkg.sv -----
// ----------------------------------------------------------------------------
// Timer queue package
// Shared types, constants and codes for the expiry-ordered timer queue and
// its storage cells.
// ----------------------------------------------------------------------------
package eotq_pkg;

	// Default sizes for the top-level parameters.
	localparam int CAPACITY_DEF = 32;
	localparam int ID_WIDTH_DEF = 8;

	// Field widths that the request and response carry.
	localparam int EXP_W  = 63;
	localparam int PID_W  = 8;
	localparam int CNT_OW = 7;

	// Most entries popped by one take request.
	localparam int POP_LIMIT = 32;
	localparam int POP_W     = $clog2(POP_LIMIT);

	// Request function codes.
	localparam logic [1:0] FUNC_INSERT = 2'd0;
	localparam logic [1:0] FUNC_REMOVE = 2'd1;
	localparam logic [1:0] FUNC_TAKE   = 2'd2;

	// Response status codes.
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_INFINITE = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_ABSENT   = 3'd3;
	localparam logic [2:0] ST_NONE     = 3'd4;
	localparam logic [2:0] ST_DUP      = 3'd5;

	// Commands broadcast to every cell of the chain.
	localparam logic [2:0] CELL_HOLD   = 3'd0;
	localparam logic [2:0] CELL_EVAL   = 3'd1;
	localparam logic [2:0] CELL_INSERT = 3'd2;
	localparam logic [2:0] CELL_REMOVE = 3'd3;
	localparam logic [2:0] CELL_POP    = 3'd4;

	typedef struct packed {
		logic [1:0]       func;
		logic [PID_W-1:0] sample_id;
		logic [EXP_W-1:0] expiry_time;
		logic             never_expires;
		logic [EXP_W-1:0] now_time;
	} req_t;

	typedef struct packed {
		logic [PID_W-1:0]  expired_id;
		logic [2:0]        status;
		logic [CNT_OW-1:0] entry_count;
		logic              last;
	} rsp_t;

	// Command and key broadcast to all cells.
	typedef struct packed {
		logic [2:0]       op;
		logic [EXP_W-1:0] expiry;
	} cell_cmd_t;

endpackage

// ----- rtl/core/eotq_cell.sv -----
// ----------------------------------------------------------------------------
// Timer queue cell
// One slot of the sorted chain. It holds an entry, compares it against the
// broadcast key, and shifts toward either neighbor on insert, remove or pop.
// ----------------------------------------------------------------------------
module eotq_cell #(
	parameter int ID_WIDTH = eotq_pkg::ID_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  eotq_pkg::cell_cmd_t        cmd,
	input  logic [ID_WIDTH-1:0]        cmd_id,
	input  logic                       left_valid,
	input  logic [eotq_pkg::EXP_W-1:0] left_exp,
	input  logic [ID_WIDTH-1:0]        left_id,
	input  logic                       left_lt,
	input  logic                       right_valid,
	input  logic [eotq_pkg::EXP_W-1:0] right_exp,
	input  logic [ID_WIDTH-1:0]        right_id,
	input  logic                       rm_sel,
	output logic                       valid,
	output logic [eotq_pkg::EXP_W-1:0] exp_time,
	output logic [ID_WIDTH-1:0]        id,
	output logic                       lt,
	output logic                       match
);
	import eotq_pkg::*;

	logic                valid_q;
	logic [EXP_W-1:0]    exp_q;
	logic [ID_WIDTH-1:0] id_q;
	logic                lt_q;
	logic                match_q;

	// Occupancy and compare flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			lt_q    <= 1'b0;
			match_q <= 1'b0;
		end else begin
			case (cmd.op)
				CELL_EVAL: begin
					lt_q    <= valid_q && (exp_q < cmd.expiry);
					match_q <= valid_q && (id_q == cmd_id);
				end
				CELL_INSERT: begin
					if (!lt_q) begin
						valid_q <= valid_q | left_valid;
					end
				end
				CELL_REMOVE: begin
					if (rm_sel) begin
						valid_q <= right_valid;
					end
				end
				CELL_POP: begin
					valid_q <= right_valid;
				end
				default: begin
				end
			endcase
		end
	end

	// Entry payload: on insert the new entry lands where the earlier ones end and
	// later entries move one cell toward the tail; remove and pop shift toward the head.
	always_ff @(posedge clk) begin
		case (cmd.op)
			CELL_INSERT: begin
				if (!lt_q) begin
					if (left_lt) begin
						exp_q <= cmd.expiry;
						id_q  <= cmd_id;
					end else begin
						exp_q <= left_exp;
						id_q  <= left_id;
					end
				end
			end
			CELL_REMOVE: begin
				if (rm_sel) begin
					exp_q <= right_exp;
					id_q  <= right_id;
				end
			end
			CELL_POP: begin
				exp_q <= right_exp;
				id_q  <= right_id;
			end
			default: begin
			end
		endcase
	end

	assign valid    = valid_q;
	assign exp_time = exp_q;
	assign id       = id_q;
	assign lt       = lt_q;
	assign match    = match_q;

endmodule

// ----- rtl/core/expiry_ordered_timer_queue.sv -----
// ----------------------------------------------------------------------------
// Expiry-ordered timer queue
// Insert and remove pass through an eval state (all cells compare) and an
// apply state that registers the response; the input stalls until idle.
// A take registers its first response after the eval state, then one per
// cycle, unless stalled, as the head cell pops; input stalls to the last response.
// A stalled response holds the sequencer until it is taken.
// Reset clears the entry count and every cell's valid flag; no clearing pass.
// ----------------------------------------------------------------------------
module expiry_ordered_timer_queue #(
	parameter int CAPACITY = eotq_pkg::CAPACITY_DEF,
	parameter int ID_WIDTH = eotq_pkg::ID_WIDTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  eotq_pkg::req_t req_data,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output eotq_pkg::rsp_t rsp_data
);
	import eotq_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = $clog2(CAPACITY);

	// Sequencer states.
	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_EVAL  = 2'd1;
	localparam logic [1:0] S_APPLY = 2'd2;
	localparam logic [1:0] S_POP   = 2'd3;

	logic [1:0]       state_q;
	req_t             req_q;
	logic [CNT_W-1:0] cnt_q;
	logic [POP_W-1:0] pop_cnt_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	// Chain wiring; index CAPACITY is the empty slot past the tail.
	logic [CAPACITY:0]    valid_vec;
	logic [EXP_W-1:0]     exp_vec [CAPACITY+1];
	logic [ID_WIDTH-1:0]  id_vec [CAPACITY+1];
	logic [CAPACITY-1:0]  lt_vec;
	logic [CAPACITY-1:0]  match_vec;

	cell_cmd_t           cmd;
	logic [ID_WIDTH-1:0] req_id;
	logic                out_free;
	logic                match_any;
	logic [IDX_W-1:0]    match_idx;
	logic                head_exp;
	logic                next_exp;
	logic                emit;
	rsp_t                emit_rsp;
	logic [CNT_W-1:0]    cnt_next;
	logic [1:0]          state_next;

	assign req_id    = ID_WIDTH'(req_q.sample_id);
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != S_IDLE);

	// Locate the matching cell; ids are unique so at most one bit is set.
	always_comb begin
		match_idx = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (match_vec[i]) begin
				match_idx = match_idx | IDX_W'(i);
			end
		end
	end
	assign match_any = |match_vec;

	// Expiry test on the two front cells drives popping and the last flag.
	assign head_exp = valid_vec[0] && (req_q.now_time >= exp_vec[0]);
	assign next_exp = valid_vec[1] && (req_q.now_time >= exp_vec[1]);

	// Sequencer decisions: cell command, response and next state.
	always_comb begin
		cmd.op     = CELL_HOLD;
		cmd.expiry = req_q.expiry_time;
		emit       = 1'b0;
		emit_rsp   = '0;
		cnt_next   = cnt_q;
		state_next = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_next = S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.op = CELL_EVAL;
				if (req_q.func == FUNC_TAKE) begin
					state_next = S_POP;
				end else if (req_q.func == FUNC_INSERT || req_q.func == FUNC_REMOVE) begin
					state_next = S_APPLY;
				end else begin
					state_next = S_IDLE;
				end
			end
			S_APPLY: begin
				if (out_free) begin
					emit          = 1'b1;
					emit_rsp.last = 1'b1;
					state_next    = S_IDLE;
					if (req_q.func == FUNC_INSERT) begin
						if (req_q.never_expires) begin
							emit_rsp.status = ST_INFINITE;
						end else if (match_any) begin
							emit_rsp.status = ST_DUP;
						end else if (cnt_q == CNT_W'(CAPACITY)) begin
							emit_rsp.status = ST_FULL;
						end else begin
							emit_rsp.status = ST_OK;
							cmd.op          = CELL_INSERT;
							cnt_next        = cnt_q + 1'b1;
						end
					end else begin
						if (match_any) begin
							emit_rsp.status = ST_OK;
							cmd.op          = CELL_REMOVE;
							cnt_next        = cnt_q - 1'b1;
						end else begin
							emit_rsp.status = ST_ABSENT;
						end
					end
					emit_rsp.entry_count = CNT_OW'(cnt_next);
				end
			end
			S_POP: begin
				if (out_free) begin
					emit = 1'b1;
					if (pop_cnt_q == '0 && !head_exp) begin
						emit_rsp.status = ST_NONE;
						emit_rsp.last   = 1'b1;
						state_next      = S_IDLE;
					end else begin
						cmd.op              = CELL_POP;
						cnt_next            = cnt_q - 1'b1;
						emit_rsp.status     = ST_OK;
						emit_rsp.expired_id = PID_W'(id_vec[0]);
						emit_rsp.last       = (pop_cnt_q == POP_W'(POP_LIMIT - 1)) || !next_exp;
						if (emit_rsp.last) begin
							state_next = S_IDLE;
						end
					end
					emit_rsp.entry_count = CNT_OW'(cnt_next);
				end
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			pop_cnt_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			cnt_q   <= cnt_next;
			if (state_q == S_EVAL) begin
				pop_cnt_q <= '0;
			end else if (cmd.op == CELL_POP) begin
				pop_cnt_q <= pop_cnt_q + 1'b1;
			end
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Request and response payload registers.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) begin
			req_q <= req_data;
		end
		if (emit) begin
			rsp_q <= emit_rsp;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	// Tail boundary: nothing valid enters from beyond the last cell.
	assign valid_vec[CAPACITY] = 1'b0;
	assign exp_vec[CAPACITY]   = '0;
	assign id_vec[CAPACITY]    = '0;

	// The row of cells, head at index zero.
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic                left_valid;
		logic [EXP_W-1:0]    left_exp;
		logic [ID_WIDTH-1:0] left_id;
		logic                left_lt;

		if (g == 0) begin : g_head
			// The head sees an always-valid, always-earlier neighbor.
			assign left_valid = 1'b1;
			assign left_exp   = '0;
			assign left_id    = '0;
			assign left_lt    = 1'b1;
		end else begin : g_body
			assign left_valid = valid_vec[g-1];
			assign left_exp   = exp_vec[g-1];
			assign left_id    = id_vec[g-1];
			assign left_lt    = lt_vec[g-1];
		end

		eotq_cell #(
			.ID_WIDTH(ID_WIDTH)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.cmd_id     (req_id),
			.left_valid (left_valid),
			.left_exp   (left_exp),
			.left_id    (left_id),
			.left_lt    (left_lt),
			.right_valid(valid_vec[g+1]),
			.right_exp  (exp_vec[g+1]),
			.right_id   (id_vec[g+1]),
			.rm_sel     (IDX_W'(g) >= match_idx),
			.valid      (valid_vec[g]),
			.exp_time   (exp_vec[g]),
			.id         (id_vec[g]),
			.lt         (lt_vec[g]),
			.match      (match_vec[g])
		);
	end

`ifndef SYNTHESIS
	// The count always equals the number of occupied cells.
	assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == cnt_q)
		else $error("entry count disagrees with occupied cells");

	// Occupied cells form an unbroken run from the head.
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(valid_vec + 1'b1))
		else $error("gap in the cell chain");

	// Ids held in the chain are unique, so a lookup hits at most one cell.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_APPLY |-> $onehot0(match_vec))
		else $error("duplicate id held in the chain");

	// A pop never runs on an empty chain.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == CELL_POP |-> valid_vec[0])
		else $error("pop from an empty chain");
`endif

endmodule

// ----- bench/expiry_ordered_timer_queue_tb.sv -----
// ----------------------------------------------------------------------------
// Expiry-ordered timer queue testbench
// Drives insert, remove and take requests into the queue and predicts every
// response from a behavioral copy of the sorted entry list. Directed cases
// cover the status codes and ordering rules. A back-pressure phase fills the
// queue and pops it in one take. Random traffic and a final run without
// idling follow.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module expiry_ordered_timer_queue_tb;
	import eotq_pkg::*;

	localparam int QCAP = CAPACITY_DEF;
	localparam logic [EXP_W-1:0] EXP_MAX = '1;
	// Function code that the block ignores.
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req_data;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp_data;

	// Behavioral copy of the sorted entry list, head at index 0.
	logic [EXP_W-1:0] held_exp [QCAP];
	logic [PID_W-1:0] held_id [QCAP];
	int held_count;

	rsp_t awaited_rsp [$];
	int mismatch_count;
	bit idle_on;
	int long_hold_cycles;

	expiry_ordered_timer_queue #(
		.CAPACITY(QCAP),
		.ID_WIDTH(ID_WIDTH_DEF)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data(req_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data(rsp_data)
	);

	// Clock generation.
	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Returns the slot that holds the given id, or -1 when it is absent.
	function automatic int find_held(input logic [PID_W-1:0] id);
		for (int i = 0; i < held_count; i++) begin
			if (held_id[i] == id)
				return i;
		end
		return -1;
	endfunction

	// Updates the entry list for one accepted request and queues the
	// responses it should produce.
	task automatic queue_predict(input req_t r);
		int pos;
		int at;
		int n;
		rsp_t o;
		o = '0;
		o.last = 1'b1;
		case (r.func)
			FUNC_INSERT: begin
				if (r.never_expires) begin
					o.status = ST_INFINITE;
				end else if (find_held(r.sample_id) >= 0) begin
					o.status = ST_DUP;
				end else if (held_count >= QCAP) begin
					o.status = ST_FULL;
				end else begin
					// New entry goes ahead of any entries with an equal expiry.
					pos = 0;
					while (pos < held_count && held_exp[pos] < r.expiry_time)
						pos++;
					for (int i = held_count; i > pos; i--) begin
						held_exp[i] = held_exp[i-1];
						held_id[i] = held_id[i-1];
					end
					held_exp[pos] = r.expiry_time;
					held_id[pos] = r.sample_id;
					held_count++;
					o.status = ST_OK;
				end
				o.entry_count = CNT_OW'(held_count);
				awaited_rsp.push_back(o);
			end
			FUNC_REMOVE: begin
				at = find_held(r.sample_id);
				if (at < 0) begin
					o.status = ST_ABSENT;
				end else begin
					for (int i = at; i + 1 < held_count; i++) begin
						held_exp[i] = held_exp[i+1];
						held_id[i] = held_id[i+1];
					end
					held_count--;
					o.status = ST_OK;
				end
				o.entry_count = CNT_OW'(held_count);
				awaited_rsp.push_back(o);
			end
			FUNC_TAKE: begin
				n = 0;
				while (n < POP_LIMIT && n < held_count && r.now_time >= held_exp[n])
					n++;
				if (n == 0) begin
					o.status = ST_NONE;
					o.entry_count = CNT_OW'(held_count);
					awaited_rsp.push_back(o);
				end else begin
					// One response per popped entry, count falling each time.
					for (int i = 0; i < n; i++) begin
						o.expired_id = held_id[i];
						o.status = ST_OK;
						o.entry_count = CNT_OW'(held_count - i - 1);
						o.last = (i == n - 1);
						awaited_rsp.push_back(o);
					end
					for (int i = 0; i + n < held_count; i++) begin
						held_exp[i] = held_exp[i+n];
						held_id[i] = held_id[i+n];
					end
					held_count -= n;
				end
			end
			default: begin
				// The unused function code is dropped by the block.
			end
		endcase
	endtask

	function automatic req_t make_request(input logic [1:0] func,
			input logic [PID_W-1:0] id, input logic [EXP_W-1:0] expiry,
			input logic never, input logic [EXP_W-1:0] now);
		req_t r;
		r.func = func;
		r.sample_id = id;
		r.expiry_time = expiry;
		r.never_expires = never;
		r.now_time = now;
		return r;
	endfunction

	// Sends one request, with an optional idle gap first, and predicts its
	// responses once the block has accepted it. Valid stays high afterwards
	// so that back-to-back requests run without an idle gap.
	task automatic send_request(input req_t r);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 11);
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= r;
		do
			@(posedge clk);
		while (req_stall);
		queue_predict(r);
	endtask

	// Builds a random request. Most requests are well formed, and removes and
	// takes are often aimed at entries that are held, so that removes hit and takes pop.
	function automatic req_t random_request();
		req_t r;
		int pick;
		r.sample_id = PID_W'($urandom_range(0, 255));
		r.expiry_time = EXP_W'({$urandom, $urandom});
		r.never_expires = ($urandom_range(0, 9) == 0);
		r.now_time = EXP_W'({$urandom, $urandom});
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			r.func = FUNC_INSERT;
			if ($urandom_range(0, 3) != 0)
				r.sample_id = PID_W'($urandom_range(0, 39));
			if ($urandom_range(0, 4) != 0)
				r.expiry_time = EXP_W'($urandom_range(0, 5000));
		end else if (pick < 65) begin
			r.func = FUNC_REMOVE;
			if (held_count > 0 && $urandom_range(0, 3) != 0)
				r.sample_id = held_id[$urandom_range(0, held_count - 1)];
		end else if (pick < 95) begin
			r.func = FUNC_TAKE;
			case ($urandom_range(0, 3))
				0, 1: begin
					if (held_count > 0)
						r.now_time = held_exp[$urandom_range(0, held_count - 1)];
				end
				2: r.now_time = EXP_W'($urandom_range(0, 5000));
				default: begin
				end
			endcase
		end else begin
			r.func = FUNC_UNUSED;
		end
		return r;
	endfunction

	// Lowers valid and waits until every predicted response has arrived.
	task automatic drain_responses();
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (awaited_rsp.size() != 0);
	endtask

	// Status codes, ordering of equal expiries and the edge values of fields.
	task automatic test_directed_cases();
		send_request(make_request(FUNC_TAKE, 8'd0, '0, 1'b0, EXP_MAX));
		send_request(make_request(FUNC_REMOVE, 8'd5, '0, 1'b0, '0));
		send_request(make_request(FUNC_INSERT, 8'd0, '0, 1'b0, '0));
		send_request(make_request(FUNC_INSERT, 8'd255, EXP_MAX, 1'b0, '0));
		send_request(make_request(FUNC_INSERT, 8'd10, 63'd1000, 1'b0, '0));
		send_request(make_request(FUNC_INSERT, 8'd11, 63'd1000, 1'b0, '0));
		send_request(make_request(FUNC_INSERT, 8'd12, 63'd5, 1'b1, '0));
		// A never-expiring insert is reported before a duplicate id.
		send_request(make_request(FUNC_INSERT, 8'd10, 63'd5, 1'b1, '0));
		send_request(make_request(FUNC_INSERT, 8'd11, 63'd3, 1'b0, '0));
		send_request(make_request(FUNC_REMOVE, 8'd77, '0, 1'b0, '0));
		send_request(make_request(FUNC_TAKE, 8'd0, '0, 1'b0, '0));
		send_request(make_request(FUNC_TAKE, 8'd0, '0, 1'b0, 63'd999));
		send_request(make_request(FUNC_UNUSED, 8'd255, EXP_MAX, 1'b1, EXP_MAX));
		send_request(make_request(FUNC_TAKE, 8'd0, '0, 1'b0, 63'd1000));
		send_request(make_request(FUNC_REMOVE, 8'd255, '0, 1'b0, '0));
		send_request(make_request(FUNC_TAKE, 8'd0, '0, 1'b0, EXP_MAX));
		send_request(make_request(FUNC_INSERT, 8'd1, 63'd50, 1'b0, '0));
		send_request(make_request(FUNC_INSERT, 8'd2, 63'd40, 1'b0, '0));
		send_request(make_request(FUNC_INSERT, 8'd3, 63'd60, 1'b0, '0));
		send_request(make_request(FUNC_INSERT, 8'd4, 63'd55, 1'b0, '0));
		send_request(make_request(FUNC_REMOVE, 8'd4, '0, 1'b0, '0));
		send_request(make_request(FUNC_REMOVE, 8'd2, '0, 1'b0, '0));
		send_request(make_request(FUNC_REMOVE, 8'd3, '0, 1'b0, '0));
		send_request(make_request(FUNC_TAKE, 8'd0, '0, 1'b0, EXP_MAX));
	endtask

	// The receiver holds off while the queue is filled, so the block backs up
	// and stalls its input. Then one take pops every entry.
	task automatic test_full_under_backpressure();
		long_hold_cycles = 300;
		for (int i = 0; i < QCAP; i++)
			send_request(make_request(FUNC_INSERT, PID_W'(100 + i),
				EXP_W'($urandom_range(0, 100000)), 1'b0, '0));
		send_request(make_request(FUNC_INSERT, 8'd200, 63'd5, 1'b0, '0));
		send_request(make_request(FUNC_INSERT, 8'd100, 63'd5, 1'b0, '0));
		send_request(make_request(FUNC_INSERT, 8'd201, 63'd5, 1'b1, '0));
		send_request(make_request(FUNC_TAKE, 8'd0, '0, 1'b0, EXP_MAX));
	endtask

	task automatic test_random_traffic(input int count);
		for (int i = 0; i < count; i++)
			send_request(random_request());
	endtask

	// Random traffic with both sides running flat out.
	task automatic test_back_to_back(input int count);
		idle_on = 1'b0;
		test_random_traffic(count);
	endtask

	// Receiver stall: random bursts, and a long hold when one is requested.
	initial begin : rsp_stall_gen
		int n;
		rsp_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_cycles > 0) begin
				rsp_stall <= 1'b1;
				repeat (long_hold_cycles) @(posedge clk);
				long_hold_cycles = 0;
				rsp_stall <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 11);
				rsp_stall <= 1'b1;
				repeat (n) @(posedge clk);
				rsp_stall <= 1'b0;
			end
		end
	end

	// Compare each accepted response with the oldest prediction.
	always @(posedge clk) begin : rsp_check
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (awaited_rsp.size() == 0) begin
				$error("response with none awaited: expired_id %0d status %0d",
					rsp_data.expired_id, rsp_data.status);
				mismatch_count++;
			end else begin
				want = awaited_rsp.pop_front();
				if (rsp_data.expired_id !== want.expired_id) begin
					$error("expired_id: expected %0d, got %0d",
						want.expired_id, rsp_data.expired_id);
					mismatch_count++;
				end
				if (rsp_data.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp_data.status);
					mismatch_count++;
				end
				if (rsp_data.entry_count !== want.entry_count) begin
					$error("entry_count: expected %0d, got %0d",
						want.entry_count, rsp_data.entry_count);
					mismatch_count++;
				end
				if (rsp_data.last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, rsp_data.last);
					mismatch_count++;
				end
			end
		end
	end

	// Main sequence.
	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_data = '0;
		held_count = 0;
		mismatch_count = 0;
		idle_on = 1'b1;
		long_hold_cycles = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_full_under_backpressure();
		test_random_traffic(30);
		test_back_to_back(15);

		drain_responses();
		repeat (40) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#4000000;
		$display("Mismatches found");
		$finish;
	end

endmodule
